[rtl/core/acdm_pkg.sv]
// ----------------------------------------------------------------------------
// acdm_pkg
// Shared types and constants of the audio channel downmix unit.
// ----------------------------------------------------------------------------
package acdm_pkg;

  localparam int MAX_IN_CHANNELS = 6;
  localparam int FIELD_CHANNELS  = 6;
  localparam int NUM_CELLS       = (MAX_IN_CHANNELS < FIELD_CHANNELS) ?
                                   MAX_IN_CHANNELS : FIELD_CHANNELS;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = 36;
  localparam int FRAC_BITS  = 12;
  localparam int CH_IDX_W   = $clog2(FIELD_CHANNELS);
  localparam int IN_CNT_W   = 3;
  localparam int OUT_CNT_W  = 2;

  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(2048);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COEF_LO_W  = 64;
  localparam int COEF_HI_W  = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_OUT_CHANNELS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IN_CHANNELS  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_LO      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_HI      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_LO     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_HI     = 3'd5;

  localparam logic [OUT_CNT_W-1:0] MODE_MONO   = 2'd1;
  localparam logic [OUT_CNT_W-1:0] MODE_STEREO = 2'd2;

  typedef struct packed {
    logic [FIELD_CHANNELS-1:0][SAMPLE_W-1:0] samples;
    logic signed [ACC_W-1:0]                 left_acc;
    logic signed [ACC_W-1:0]                 right_acc;
    logic                                    block_end;
  } acdm_item_t;

endpackage

[rtl/core/acdm_cell.sv]
// ----------------------------------------------------------------------------
// acdm_cell
// One channel cell: when active, adds this channel's weighted sample to both running sums.
// ----------------------------------------------------------------------------
module acdm_cell import acdm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       active,
  input  logic [CH_IDX_W-1:0]        chan,
  input  logic signed [COEF_W-1:0]   left_coef,
  input  logic signed [COEF_W-1:0]   right_coef,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  acdm_item_t                 in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output acdm_item_t                 out_item
);

  logic signed [SAMPLE_W-1:0] sample;
  logic signed [PROD_W-1:0]   left_prod;
  logic signed [PROD_W-1:0]   right_prod;
  acdm_item_t                 item_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    sample     = signed'(in_item.samples[chan]);
    left_prod  = sample * left_coef;
    right_prod = sample * right_coef;
    item_next  = in_item;
    if (active) begin
      item_next.left_acc  = in_item.left_acc + ACC_W'(left_prod);
      item_next.right_acc = in_item.right_acc + ACC_W'(right_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

[rtl/core/acdm_mix_out.sv]
// ----------------------------------------------------------------------------
// acdm_mix_out
// Output stage: Q12 rounding, mode selection and the output register.
// ----------------------------------------------------------------------------
module acdm_mix_out import acdm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [OUT_CNT_W-1:0] mode,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  acdm_item_t           in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  left_or_mono,
  output logic [SAMPLE_W-1:0]  right_mix,
  output logic                 block_end_out
);

  logic [ACC_W-1:0]    left_biased;
  logic [ACC_W-1:0]    right_biased;
  logic [SAMPLE_W-1:0] left_next;
  logic [SAMPLE_W-1:0] right_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    left_biased  = in_item.left_acc + ROUND_BIAS;
    right_biased = in_item.right_acc + ROUND_BIAS;
    case (mode)
      MODE_STEREO: begin
        left_next  = left_biased[FRAC_BITS +: SAMPLE_W];
        right_next = right_biased[FRAC_BITS +: SAMPLE_W];
      end
      MODE_MONO: begin
        left_next  = left_biased[FRAC_BITS +: SAMPLE_W];
        right_next = '0;
      end
      default: begin
        // undefined mode: raw channels 0 and 1 pass through
        left_next  = in_item.samples[0];
        right_next = in_item.samples[1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      left_or_mono  <= left_next;
      right_mix     <= right_next;
      block_end_out <= in_item.block_end;
    end
  end

endmodule

[rtl/core/audio_channel_downmix_unit.sv]
// ----------------------------------------------------------------------------
// audio_channel_downmix_unit
// Matrix downmix of six Q12-weighted channels to stereo or mono.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                      tuser/tlast
//  s_axis    in   sample_ch0 .. sample_ch5, 16b each      tlast = block_end
//  m_axis    out  left_or_mono[15:0], right_mix[31:16]    tlast = block_end_out
//  cfg       in   cfg_addr = register index, cfg_wdata    cfg_wen strobe
//
//  One transfer per cycle in each direction while m_axis_tready is high; the pipeline
//  registers are the channel cells in order, then the rounding/output register.
//  Each stage holds its item while its successor is full, so bubbles collapse.
//  rst is synchronous: clears all stage valids and restores register defaults.
// ----------------------------------------------------------------------------
module audio_channel_downmix_unit import acdm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [FIELD_CHANNELS*SAMPLE_W-1:0] s_axis_tdata, // sample_ch0 .. sample_ch5
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*SAMPLE_W-1:0]         m_axis_tdata,  // left_or_mono, right_mix
  output logic                          m_axis_tlast,
  input  logic                          cfg_wen,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  logic [OUT_CNT_W-1:0] out_channels;
  logic [IN_CNT_W-1:0]  in_channels;
  logic [COEF_LO_W-1:0] left_coefs_low;
  logic [COEF_HI_W-1:0] left_coefs_high;
  logic [COEF_LO_W-1:0] right_coefs_low;
  logic [COEF_HI_W-1:0] right_coefs_high;

  logic [COEF_LO_W+COEF_HI_W-1:0] left_coefs;
  logic [COEF_LO_W+COEF_HI_W-1:0] right_coefs;
  logic [IN_CNT_W-1:0]            n_active;

  logic [NUM_CELLS:0] link_valid;
  logic [NUM_CELLS:0] link_ready;
  acdm_item_t         link_item [NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_channels     <= MODE_STEREO;
      in_channels      <= IN_CNT_W'(6);
      left_coefs_low   <= '0;
      left_coefs_high  <= '0;
      right_coefs_low  <= '0;
      right_coefs_high <= '0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_OUT_CHANNELS: out_channels     <= cfg_wdata[OUT_CNT_W-1:0];
        REG_IN_CHANNELS:  in_channels      <= cfg_wdata[IN_CNT_W-1:0];
        REG_LEFT_LO:      left_coefs_low   <= cfg_wdata[COEF_LO_W-1:0];
        REG_LEFT_HI:      left_coefs_high  <= cfg_wdata[COEF_HI_W-1:0];
        REG_RIGHT_LO:     right_coefs_low  <= cfg_wdata[COEF_LO_W-1:0];
        REG_RIGHT_HI:     right_coefs_high <= cfg_wdata[COEF_HI_W-1:0];
        default: ;
      endcase
    end
  end

  assign left_coefs  = {left_coefs_high, left_coefs_low};
  assign right_coefs = {right_coefs_high, right_coefs_low};
  assign n_active    = (in_channels > IN_CNT_W'(NUM_CELLS)) ?
                       IN_CNT_W'(NUM_CELLS) : in_channels;

  always_comb begin
    link_item[0].samples   = s_axis_tdata;
    link_item[0].left_acc  = '0;
    link_item[0].right_acc = '0;
    link_item[0].block_end = s_axis_tlast;
  end
  assign link_valid[0] = s_axis_tvalid;
  assign s_axis_tready = link_ready[0];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    acdm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .active     (IN_CNT_W'(k) < n_active),
      .chan       (CH_IDX_W'(k)),
      .left_coef  (signed'(left_coefs[k*COEF_W +: COEF_W])),
      .right_coef (signed'(right_coefs[k*COEF_W +: COEF_W])),
      .in_valid   (link_valid[k]),
      .in_ready   (link_ready[k]),
      .in_item    (link_item[k]),
      .out_valid  (link_valid[k+1]),
      .out_ready  (link_ready[k+1]),
      .out_item   (link_item[k+1])
    );
  end

  acdm_mix_out u_mix_out (
    .clk           (clk),
    .rst           (rst),
    .mode          (out_channels),
    .in_valid      (link_valid[NUM_CELLS]),
    .in_ready      (link_ready[NUM_CELLS]),
    .in_item       (link_item[NUM_CELLS]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .left_or_mono  (m_axis_tdata[SAMPLE_W-1:0]),
    .right_mix     (m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .block_end_out (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_reset_empty : assert property (@(posedge clk)
    rst |=> (link_valid[NUM_CELLS:1] == '0) && !m_axis_tvalid)
    else $error("pipeline not empty after reset");

  a_empty_out_ready : assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

  a_accept_lands : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> link_valid[1])
    else $error("accepted transfer missing from first cell");
`endif

endmodule
